[rtl/bc1_block_decoder_macros.svh]
// Assertion macros of the BC1 block decoder RTL, used by the pixel sequencer.
`ifndef BC1_BLOCK_DECODER_MACROS_SVH
`define BC1_BLOCK_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge outside reset.
`define BC1_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BC1_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BC1_ASSERT_IMPL(name, clk, rst, ante, cons)
`define BC1_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[rtl/bc1_pkg.sv]
// Types, constants and color functions of the BC1 block decoder.
package bc1_pkg;

  localparam int unsigned Pixels = 16;
  localparam int unsigned PixW   = $clog2(Pixels);

  localparam logic [PixW-1:0] PixLast     = PixW'(Pixels - 1);
  localparam logic [7:0]      AlphaOpaque = 8'hFF;

  // 683 / 2048 matches a divide by three for every sum below 2048.
  localparam logic [9:0] Recip3      = 10'd683;
  localparam int unsigned Recip3Shift = 11;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef rgb_t [3:0] palette_t;

  // Decoded block handed from the palette stage to the pixel sequencer.
  typedef struct packed {
    palette_t    palette;
    logic [31:0] selectors;
  } block_req_t;

  function automatic logic [7:0] widen5(logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] x);
    return {x, x[5:4]};
  endfunction

  function automatic rgb_t widen565(logic [15:0] c);
    rgb_t o;
    o.red   = widen5(c[15:11]);
    o.green = widen6(c[10:5]);
    o.blue  = widen5(c[4:0]);
    return o;
  endfunction

  // (2*a + b) / 3, truncating.
  function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = {1'b0, a, 1'b0} + {2'b00, b};
    prod = {10'd0, sum} * {10'd0, Recip3};
    return prod[Recip3Shift+7:Recip3Shift];
  endfunction

  function automatic rgb_t blend_rgb(rgb_t a, rgb_t b);
    rgb_t o;
    o.red   = blend(a.red, b.red);
    o.green = blend(a.green, b.green);
    o.blue  = blend(a.blue, b.blue);
    return o;
  endfunction

endpackage

[rtl/bc1_block_if.sv]
// Request channel carrying one compressed BC1 block.
interface bc1_block_if;
  logic        valid;
  logic        ready;
  logic [15:0] endpoint_zero;
  logic [15:0] endpoint_one;
  logic [31:0] selector_bits;

  modport source (output valid, output endpoint_zero, output endpoint_one,
                  output selector_bits, input ready);
  modport sink   (input valid, input endpoint_zero, input endpoint_one,
                  input selector_bits, output ready);
endinterface

[rtl/bc1_pixel_if.sv]
// Request channel carrying one decoded pixel.
interface bc1_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [bc1_pkg::PixW-1:0]  pixel_number;
  logic [7:0]                red;
  logic [7:0]                green;
  logic [7:0]                blue;
  logic [7:0]                alpha;
  logic                      last_pixel;

  modport source (output valid, output pixel_number, output red, output green,
                  output blue, output alpha, output last_pixel, input ready);
  modport sink   (input valid, input pixel_number, input red, input green,
                  input blue, input alpha, input last_pixel, output ready);
endinterface

[rtl/bc1_palette.sv]
// Input register and four-color palette build of the BC1 decoder.
module bc1_palette (
  input  logic                clk,
  input  logic                rst,
  bc1_block_if.sink           blk,
  output logic                req_valid,
  output bc1_pkg::block_req_t req,
  input  logic                req_take
);

  logic        valid;
  logic [15:0] endpoint_zero;
  logic [15:0] endpoint_one;
  logic [31:0] selector_bits;

  bc1_pkg::rgb_t c0;
  bc1_pkg::rgb_t c1;

  assign blk.ready = !valid || req_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (blk.ready) begin
      valid <= blk.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (blk.valid && blk.ready) begin
      endpoint_zero <= blk.endpoint_zero;
      endpoint_one  <= blk.endpoint_one;
      selector_bits <= blk.selector_bits;
    end
  end

  always_comb begin
    c0 = bc1_pkg::widen565(endpoint_zero);
    c1 = bc1_pkg::widen565(endpoint_one);
    req.palette[0] = c0;
    req.palette[1] = c1;
    req.palette[2] = bc1_pkg::blend_rgb(c0, c1);
    req.palette[3] = bc1_pkg::blend_rgb(c1, c0);
    req.selectors  = selector_bits;
  end

  assign req_valid = valid;

endmodule

[rtl/bc1_pixel_seq.sv]
// Pixel sequencer: holds one palette and walks the sixteen pixels out.
`include "bc1_block_decoder_macros.svh"

module bc1_pixel_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  bc1_pkg::block_req_t req,
  output logic                req_take,
  bc1_pixel_if.source         pix
);

  logic                     busy;
  logic [bc1_pkg::PixW-1:0] cnt;
  bc1_pkg::palette_t        palette;
  logic [31:0]              selectors;

  logic          emit;
  logic          last;
  logic [1:0]    idx;
  bc1_pkg::rgb_t color;

  assign emit     = busy && (!pix.valid || pix.ready);
  assign last     = cnt == bc1_pkg::PixLast;
  assign req_take = req_valid && (!busy || (emit && last));
  assign idx      = selectors[{cnt, 1'b0} +: 2];
  assign color    = palette[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      pix.valid <= 1'b0;
    end else begin
      if (emit) begin
        cnt <= cnt + 1'b1;
      end
      if (req_take) begin
        busy <= 1'b1;
      end else if (emit && last) begin
        busy <= 1'b0;
      end
      if (emit) begin
        pix.valid <= 1'b1;
      end else if (pix.ready) begin
        pix.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      palette   <= req.palette;
      selectors <= req.selectors;
    end
    if (emit) begin
      pix.pixel_number <= cnt;
      pix.red          <= color.red;
      pix.green        <= color.green;
      pix.blue         <= color.blue;
      pix.alpha        <= bc1_pkg::AlphaOpaque;
      pix.last_pixel   <= last;
    end
  end

  `BC1_ASSERT_IMPL(a_last_flag_on_final, clk, rst, pix.valid && pix.last_pixel, pix.pixel_number == bc1_pkg::PixLast)
  `BC1_ASSERT_IMPL(a_idle_count_zero, clk, rst, !busy, cnt == '0)
  `BC1_ASSERT_NEXT(a_busy_mid_block, clk, rst, emit && !last, busy)

endmodule

[rtl/bc1_block_decoder.sv]
// Top level of the BC1 block decoder: palette stage and pixel sequencer.
//
//   channel  dir  payload                                        per block
//   blk      in   endpoint_zero, endpoint_one, selector_bits     1 request
//   pix      out  pixel_number, red, green, blue, alpha, last    16 requests
//
// The pixel sequencer emits one pixel a cycle while pix is not stalled.
// A taken block passes the input register and the sequencer palette register before its first pixel shows.
// Next block waits in the input register and loads as pixel 15 leaves.
// A stall on pix holds the output register and the sequencer count.
// Synchronous reset clears valid flags and the count; no memories to sweep.
module bc1_block_decoder (
  input  logic        clk,
  input  logic        rst,
  bc1_block_if.sink   blk,
  bc1_pixel_if.source pix
);

  logic                req_valid;
  logic                req_take;
  bc1_pkg::block_req_t req;

  // Register the block and build the palette.
  bc1_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .blk       (blk),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take)
  );

  // Hold the palette and advance through the pixels.
  bc1_pixel_seq u_pixel_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .pix       (pix)
  );

endmodule
